// ===== rtl/pixel_to_hex_cell_top_macros.svh =====
// Assertion macros for the checker file of the pixel to cell mapper
`ifndef PIXEL_TO_HEX_CELL_TOP_MACROS_SVH
`define PIXEL_TO_HEX_CELL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define P2HC_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("p2hc check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define P2HC_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("p2hc check failed");

`endif

// ===== rtl/p2hc_pkg.sv =====
// Shared constants, types and divider step functions of the pixel to cell mapper
package p2hc_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_W      = 10;
    localparam int OUT_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int NUM_W      = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int EXT_W      = NUM_W + 1;
    localparam int DIV_W      = CFG_W + 1;
    localparam int TRIAL_W    = (EXT_W > DIV_W) ? EXT_W : DIV_W;
    localparam int PROD_W     = NUM_W + CFG_W;
    localparam int CMP_W      = PROD_W + 2;
    localparam int ARITH_W    = (NUM_W + 2 > OUT_W) ? NUM_W + 2 : OUT_W;
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] RST_COLUMN_SPACING = CFG_W'(48);
    localparam logic [CFG_W-1:0] RST_ROW_SPACING    = CFG_W'(64);
    localparam logic [CFG_W-1:0] RST_SLOPE_RUN      = CFG_W'(16);
    localparam logic [CFG_W-1:0] RST_SLOPE_RISE     = CFG_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMN_SPACING = 2'd0,
        REG_ROW_SPACING    = 2'd1,
        REG_SLOPE_RUN      = 2'd2,
        REG_SLOPE_RISE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] col_sp;
        logic [CFG_W-1:0] row_sp;
        logic [CFG_W-1:0] run;
        logic [CFG_W-1:0] rise;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        lane_t x;
        lane_t y;
        lane_t f;
        logic  fneg;
    } div_stage_t;

    function automatic lane_t div_step(lane_t a, logic [DIV_W-1:0] d);
        logic [EXT_W-1:0]   trial;
        logic [TRIAL_W-1:0] tw;
        logic [TRIAL_W-1:0] dw;
        lane_t              r;
        trial = {a.rem, a.num[NUM_W-1]};
        tw    = TRIAL_W'(trial);
        dw    = TRIAL_W'(d);
        r.num = {a.num[NUM_W-2:0], 1'b0};
        if (tw >= dw)
        begin
            r.rem = NUM_W'(tw - dw);
            r.quo = {a.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = NUM_W'(tw);
            r.quo = {a.quo[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_stage_t div_advance(div_stage_t s, logic [DIV_W-1:0] dx,
                                               logic [DIV_W-1:0] dy);
        div_stage_t r;
        r.x    = div_step(s.x, dx);
        r.y    = div_step(s.y, dy);
        r.f    = div_step(s.f, dy);
        r.fneg = s.fneg;
        return r;
    endfunction

endpackage

// ===== rtl/p2hc_cfg.sv =====
// Configuration registers with zero-spacing substitution
module p2hc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p2hc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [p2hc_pkg::CFG_W-1:0]       cfg_data,
    output p2hc_pkg::cfg_t                   cfg
);

    logic [p2hc_pkg::CFG_W-1:0] col_sp_reg, col_sp_next;
    logic [p2hc_pkg::CFG_W-1:0] row_sp_reg, row_sp_next;
    logic [p2hc_pkg::CFG_W-1:0] run_reg, run_next;
    logic [p2hc_pkg::CFG_W-1:0] rise_reg, rise_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        col_sp_next = col_sp_reg;
        row_sp_next = row_sp_reg;
        run_next    = run_reg;
        rise_next   = rise_reg;
        if (cfg_valid)
        begin
            case (p2hc_pkg::reg_idx_t'(cfg_index))
                p2hc_pkg::REG_COLUMN_SPACING: col_sp_next = cfg_data;
                p2hc_pkg::REG_ROW_SPACING:    row_sp_next = cfg_data;
                p2hc_pkg::REG_SLOPE_RUN:      run_next    = cfg_data;
                p2hc_pkg::REG_SLOPE_RISE:     rise_next   = cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sp_reg <= p2hc_pkg::RST_COLUMN_SPACING;
            row_sp_reg <= p2hc_pkg::RST_ROW_SPACING;
            run_reg    <= p2hc_pkg::RST_SLOPE_RUN;
            rise_reg   <= p2hc_pkg::RST_SLOPE_RISE;
        end
        else
        begin
            col_sp_reg <= col_sp_next;
            row_sp_reg <= row_sp_next;
            run_reg    <= run_next;
            rise_reg   <= rise_next;
        end
    end

    // treat a zero spacing as one
    assign cfg.col_sp = (col_sp_reg == '0) ? p2hc_pkg::CFG_W'(1) : col_sp_reg;
    assign cfg.row_sp = (row_sp_reg == '0) ? p2hc_pkg::CFG_W'(1) : row_sp_reg;
    assign cfg.run    = run_reg;
    assign cfg.rise   = rise_reg;

endmodule

// ===== rtl/p2hc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes
module p2hc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  p2hc_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [p2hc_pkg::COORD_BITS-1:0]   in_x,
    input  logic [p2hc_pkg::COORD_BITS-1:0]   in_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output p2hc_pkg::div_stage_t              out
);

    p2hc_pkg::div_stage_t         st_reg [0:p2hc_pkg::NUM_W];
    p2hc_pkg::div_stage_t         st_next [1:p2hc_pkg::NUM_W];
    p2hc_pkg::div_stage_t         st0_next;
    logic                         v_reg  [0:p2hc_pkg::NUM_W];
    logic                         v_next [0:p2hc_pkg::NUM_W];
    logic                         rdy    [0:p2hc_pkg::NUM_W];
    logic [p2hc_pkg::DIV_W-1:0]   dx;
    logic [p2hc_pkg::DIV_W-1:0]   dy;
    logic [p2hc_pkg::EXT_W-1:0]   py_w;
    logic [p2hc_pkg::EXT_W-1:0]   sh_w;
    logic [p2hc_pkg::EXT_W-1:0]   m_w;

    assign dx = {cfg.col_sp, 1'b0};
    assign dy = p2hc_pkg::DIV_W'(cfg.row_sp);

    // floor lane: divide |py - rise| or its one's complement counterpart
    always_comb
    begin
        py_w = p2hc_pkg::EXT_W'(in_y);
        sh_w = p2hc_pkg::EXT_W'(cfg.rise);
        if (py_w >= sh_w)
        begin
            m_w           = py_w - sh_w;
            st0_next.fneg = 1'b0;
        end
        else
        begin
            m_w           = sh_w - py_w - p2hc_pkg::EXT_W'(1);
            st0_next.fneg = 1'b1;
        end
        st0_next.x.num = p2hc_pkg::NUM_W'(in_x);
        st0_next.x.rem = '0;
        st0_next.x.quo = '0;
        st0_next.y.num = p2hc_pkg::NUM_W'(in_y);
        st0_next.y.rem = '0;
        st0_next.y.quo = '0;
        st0_next.f.num = m_w[p2hc_pkg::NUM_W-1:0];
        st0_next.f.rem = '0;
        st0_next.f.quo = '0;
    end

    assign rdy[p2hc_pkg::NUM_W] = !v_reg[p2hc_pkg::NUM_W] || out_ready;
    assign v_next[0]            = rdy[0] ? in_valid : v_reg[0];

    for (genvar i = 0; i < p2hc_pkg::NUM_W; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    for (genvar i = 1; i <= p2hc_pkg::NUM_W; i++)
    begin : g_step
        assign st_next[i] = p2hc_pkg::div_advance(st_reg[i-1], dx, dy);
        assign v_next[i]  = rdy[i] ? v_reg[i-1] : v_reg[i];
    end

    for (genvar i = 0; i <= p2hc_pkg::NUM_W; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar i = 1; i <= p2hc_pkg::NUM_W; i++)
    begin : g_data
        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[p2hc_pkg::NUM_W];
    assign out       = st_reg[p2hc_pkg::NUM_W];

endmodule

// ===== rtl/p2hc_sel.sv =====
// Segment products, slope comparisons and final cell arithmetic, three stages
module p2hc_sel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  p2hc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  p2hc_pkg::div_stage_t          in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [p2hc_pkg::OUT_W-1:0]    col,
    output logic [p2hc_pkg::OUT_W-1:0]    row
);

    typedef enum logic [1:0] {
        COL_LEFT  = 2'd0,
        COL_SAME  = 2'd1,
        COL_RIGHT = 2'd2
    } col_sel_t;

    typedef enum logic [1:0] {
        ROW_UP    = 2'd0,
        ROW_SAME  = 2'd1,
        ROW_FLOOR = 2'd2
    } row_sel_t;

    typedef struct packed {
        logic [p2hc_pkg::NUM_W-1:0]  xq;
        logic [p2hc_pkg::NUM_W-1:0]  yq;
        logic [p2hc_pkg::NUM_W-1:0]  fq;
        logic                        fneg;
        logic                        seg_a;
        logic                        seg_b;
        logic                        seg_c;
        logic [p2hc_pkg::PROD_W-1:0] ysw;
        logic [p2hc_pkg::PROD_W-1:0] xsh;
        logic [p2hc_pkg::PROD_W-1:0] offsh;
        logic [p2hc_pkg::PROD_W-1:0] shsw;
    } s1_t;

    typedef struct packed {
        logic [p2hc_pkg::NUM_W-1:0] xq;
        logic [p2hc_pkg::NUM_W-1:0] yq;
        logic [p2hc_pkg::NUM_W-1:0] fq;
        logic                       fneg;
        col_sel_t                   csel;
        row_sel_t                   rsel;
    } s2_t;

    s1_t                           s1_reg, s1_next;
    s2_t                           s2_reg, s2_next;
    logic [p2hc_pkg::OUT_W-1:0]    col_reg, col_next;
    logic [p2hc_pkg::OUT_W-1:0]    row_reg, row_next;
    logic                          v1_reg, v2_reg, v3_reg;
    logic                          rdy1, rdy2, rdy3;
    logic [p2hc_pkg::EXT_W-1:0]    xm_w;
    logic [p2hc_pkg::EXT_W-1:0]    offw;
    logic [p2hc_pkg::CFG_W-1:0]    off;
    logic [p2hc_pkg::CMP_W-1:0]    ysw_c, xsh_c, offsh_c, shsw_c;
    logic                          up, same;
    logic [p2hc_pkg::ARITH_W-1:0]  col_w, row_w;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: segment flags and slope products
    always_comb
    begin
        xm_w          = p2hc_pkg::EXT_W'(in.x.rem);
        offw          = xm_w - p2hc_pkg::EXT_W'(cfg.col_sp);
        off           = offw[p2hc_pkg::CFG_W-1:0];
        s1_next.xq    = in.x.quo;
        s1_next.yq    = in.y.quo;
        s1_next.fq    = in.f.quo;
        s1_next.fneg  = in.fneg;
        s1_next.seg_a = xm_w < p2hc_pkg::EXT_W'(cfg.run);
        s1_next.seg_b = xm_w < p2hc_pkg::EXT_W'(cfg.col_sp);
        s1_next.seg_c = xm_w < (p2hc_pkg::EXT_W'(cfg.run) + p2hc_pkg::EXT_W'(cfg.col_sp));
        s1_next.ysw   = p2hc_pkg::PROD_W'(in.y.rem) * p2hc_pkg::PROD_W'(cfg.run);
        s1_next.xsh   = p2hc_pkg::PROD_W'(in.x.rem) * p2hc_pkg::PROD_W'(cfg.rise);
        s1_next.offsh = p2hc_pkg::PROD_W'(off) * p2hc_pkg::PROD_W'(cfg.rise);
        s1_next.shsw  = p2hc_pkg::PROD_W'(cfg.rise) * p2hc_pkg::PROD_W'(cfg.run);
    end

    // stage 2: pick the cell among the three candidates
    always_comb
    begin
        ysw_c        = p2hc_pkg::CMP_W'(s1_reg.ysw);
        xsh_c        = p2hc_pkg::CMP_W'(s1_reg.xsh);
        offsh_c      = p2hc_pkg::CMP_W'(s1_reg.offsh);
        shsw_c       = p2hc_pkg::CMP_W'(s1_reg.shsw);
        s2_next.xq   = s1_reg.xq;
        s2_next.yq   = s1_reg.yq;
        s2_next.fq   = s1_reg.fq;
        s2_next.fneg = s1_reg.fneg;
        up           = 1'b0;
        same         = 1'b0;
        s2_next.csel = COL_SAME;
        s2_next.rsel = ROW_SAME;
        if (s1_reg.seg_a)
        begin
            up   = (ysw_c + xsh_c) < shsw_c;
            same = ysw_c < (shsw_c + xsh_c);
            if (up)
            begin
                s2_next.csel = COL_LEFT;
                s2_next.rsel = ROW_UP;
            end
            else if (!same)
            begin
                s2_next.csel = COL_LEFT;
            end
        end
        else if (s1_reg.seg_b)
        begin
            s2_next.csel = COL_SAME;
        end
        else if (s1_reg.seg_c)
        begin
            up   = ysw_c < offsh_c;
            same = (ysw_c + offsh_c) < {shsw_c[p2hc_pkg::CMP_W-2:0], 1'b0};
            if (up)
            begin
                s2_next.csel = COL_RIGHT;
                s2_next.rsel = ROW_UP;
            end
            else if (!same)
            begin
                s2_next.csel = COL_RIGHT;
            end
        end
        else
        begin
            s2_next.csel = COL_RIGHT;
            s2_next.rsel = ROW_FLOOR;
        end
    end

    // stage 3: column and row arithmetic, wrapped to the result width
    always_comb
    begin
        col_w = p2hc_pkg::ARITH_W'({s2_reg.xq, 1'b0});
        case (s2_reg.csel)
            COL_LEFT:  col_w = col_w - p2hc_pkg::ARITH_W'(1);
            COL_RIGHT: col_w = col_w + p2hc_pkg::ARITH_W'(1);
            default:   ;
        endcase
        case (s2_reg.rsel)
            ROW_UP:    row_w = p2hc_pkg::ARITH_W'(s2_reg.yq) - p2hc_pkg::ARITH_W'(1);
            ROW_FLOOR: row_w = s2_reg.fneg ? ~p2hc_pkg::ARITH_W'(s2_reg.fq)
                                           :  p2hc_pkg::ARITH_W'(s2_reg.fq);
            default:   row_w = p2hc_pkg::ARITH_W'(s2_reg.yq);
        endcase
        col_next = col_w[p2hc_pkg::OUT_W-1:0];
        row_next = row_w[p2hc_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign out_valid = v3_reg;
    assign col       = col_reg;
    assign row       = row_reg;

endmodule

// ===== rtl/pixel_to_hex_cell_top.sv =====
// Top level of the pixel to offset-coordinate cell mapper
//
// Takes one pixel word (x, y) on the s_ stream and returns one cell word
// (column, row, both 13-bit two's complement) on the m_ stream, in order.
// Flat-topped cells, odd columns shifted down by half a row; tile spacing
// and edge slope come from four registers written over the cfg_ channel
// (index 0 column spacing, 1 row spacing, 2 slope run, 3 slope rise).
// Write registers only while no word is in flight.
//
// Throughput: one word per clock while m_tready is high. From acceptance to
// m_tvalid a word passes the input register, the restoring divider that
// resolves one quotient bit per stage (12 stages for 12-bit coordinates),
// the multiply stage, the compare stage and the output register.
// When m_tready is low the result holds in the output register and words
// behind it close up into empty stages; s_tready drops only when every
// stage is full. Reset empties the pipeline and reloads register defaults
// (48, 64, 16, 32); cfg_ready is always high.
module pixel_to_hex_cell_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [p2hc_pkg::IN_DATA_W-1:0]      s_tdata,   // pixel_x, pixel_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [p2hc_pkg::OUT_DATA_W-1:0]     m_tdata,   // cell_column, cell_row, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [p2hc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p2hc_pkg::CFG_W-1:0]          cfg_data
);

    p2hc_pkg::cfg_t                cfg;
    p2hc_pkg::div_stage_t          div_out;
    logic                          div_valid;
    logic                          div_ready;
    logic [p2hc_pkg::OUT_W-1:0]    cell_column;
    logic [p2hc_pkg::OUT_W-1:0]    cell_row;

    p2hc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    p2hc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[p2hc_pkg::COORD_BITS-1:0]),
        .in_y      (s_tdata[2*p2hc_pkg::COORD_BITS-1:p2hc_pkg::COORD_BITS]),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out       (div_out)
    );

    p2hc_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in        (div_out),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .col       (cell_column),
        .row       (cell_row)
    );

    assign m_tdata = {{(p2hc_pkg::OUT_DATA_W - 2*p2hc_pkg::OUT_W){1'b0}}, cell_row, cell_column};

endmodule

// ===== rtl/p2hc_check.sv =====
// Port-level checker for the pixel to cell mapper, bound to the top level
`include "pixel_to_hex_cell_top_macros.svh"

module p2hc_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [p2hc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [p2hc_pkg::OUT_W-1:0] out_col;

    assign out_col = m_tdata[p2hc_pkg::OUT_W-1:0];

    // hold a stalled result word
    `P2HC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `P2HC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // an empty output stage means the whole pipeline can advance
    `P2HC_ASSERT_NOW(a_in_open, !m_tvalid, s_tready)
    // the column never lies further left than one column off the grid
    `P2HC_ASSERT_NOW(a_col_floor, m_tvalid && out_col[p2hc_pkg::OUT_W-1], out_col == '1)

endmodule

bind pixel_to_hex_cell_top p2hc_check u_check (.*);

// ===== tb/pixel_to_hex_cell_top_test.sv =====
// Testbench for the pixel to offset-coordinate cell mapper, checked against its own predictor
`timescale 1ns / 100ps

module pixel_to_hex_cell_top_test;

    typedef struct {
        logic [p2hc_pkg::OUT_W-1:0] column;
        logic [p2hc_pkg::OUT_W-1:0] row;
    } cell_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [p2hc_pkg::IN_DATA_W-1:0]      s_tdata = '0;     // pixel_x, pixel_y
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [p2hc_pkg::OUT_DATA_W-1:0]     m_tdata;          // cell_column, cell_row, zero pad
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    p2hc_pkg::reg_idx_t                  cfg_index = p2hc_pkg::REG_COLUMN_SPACING;
    logic [p2hc_pkg::CFG_W-1:0]          cfg_data = '0;

    logic [p2hc_pkg::IN_DATA_W-1:0]      pixel_words[$];
    cell_t                               cells_due[$];
    int                                  fail_count = 0;
    int                                  cells_seen = 0;
    bit                                  steady = 1'b0;
    bit                                  hold_done = 1'b0;
    int                                  hold_left = 0;

    logic [p2hc_pkg::CFG_W-1:0]          col_spacing = p2hc_pkg::RST_COLUMN_SPACING;
    logic [p2hc_pkg::CFG_W-1:0]          row_spacing = p2hc_pkg::RST_ROW_SPACING;
    logic [p2hc_pkg::CFG_W-1:0]          edge_run = p2hc_pkg::RST_SLOPE_RUN;
    logic [p2hc_pkg::CFG_W-1:0]          edge_rise = p2hc_pkg::RST_SLOPE_RISE;

    pixel_to_hex_cell_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("pixel_to_hex_cell_top: mismatch");
        $finish;
    end

    function automatic cell_t map_pixel_to_cell(logic [p2hc_pkg::COORD_BITS-1:0] pix_x,
                                                logic [p2hc_pkg::COORD_BITS-1:0] pix_y);
        longint px, py, xs, ys, sw, sh, span, xm, xd, ym, yd, off, num, col, row;
        cell_t  c;
        px   = longint'(pix_x);
        py   = longint'(pix_y);
        xs   = (col_spacing == 0) ? 1 : longint'(col_spacing);
        ys   = (row_spacing == 0) ? 1 : longint'(row_spacing);
        sw   = longint'(edge_run);
        sh   = longint'(edge_rise);
        span = 2 * xs;
        xm   = px % span;
        xd   = px / span;
        ym   = py % ys;
        yd   = py / ys;
        if (xm < sw)
        begin
            if (ym * sw < sh * sw - xm * sh)
            begin
                col = 2 * xd - 1;
                row = yd - 1;
            end
            else if (ym * sw < sh * sw + xm * sh)
            begin
                col = 2 * xd;
                row = yd;
            end
            else
            begin
                col = 2 * xd - 1;
                row = yd;
            end
        end
        else if (xm < xs)
        begin
            col = 2 * xd;
            row = yd;
        end
        else if (xm < sw + xs)
        begin
            off = xm - xs;
            if (ym * sw < off * sh)
            begin
                col = 2 * xd + 1;
                row = yd - 1;
            end
            else if (ym * sw < 2 * sh * sw - off * sh)
            begin
                col = 2 * xd;
                row = yd;
            end
            else
            begin
                col = 2 * xd + 1;
                row = yd;
            end
        end
        else
        begin
            // floor the row, so pixels above the slope rise land on a negative row
            col = 2 * xd + 1;
            num = py - sh;
            row = num / ys;
            if ((num % ys) != 0 && num < 0)
                row = row - 1;
        end
        c.column = p2hc_pkg::OUT_W'(col);
        c.row    = p2hc_pkg::OUT_W'(row);
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: cell word %0d: %s", $realtime, cells_seen, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                cells_due.insert(cells_due.size(),
                    map_pixel_to_cell(s_tdata[p2hc_pkg::COORD_BITS-1:0],
                                      s_tdata[2*p2hc_pkg::COORD_BITS-1:p2hc_pkg::COORD_BITS]));
            if (pixel_words.size() != 0 && (steady || $urandom_range(99) >= 26))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_words.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && cells_seen >= 500)
        begin
            m_tready  <= 1'b0;
            hold_left <= 120;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= steady || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        cell_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cells_due.size() == 0)
            begin
                report_mismatch("arrived with nothing outstanding");
            end
            else
            begin
                want = cells_due.pop_front();
                if (m_tdata[p2hc_pkg::OUT_W-1:0] !== want.column)
                    report_mismatch($sformatf("column got %0d expected %0d",
                                              $signed(m_tdata[p2hc_pkg::OUT_W-1:0]),
                                              $signed(want.column)));
                if (m_tdata[2*p2hc_pkg::OUT_W-1:p2hc_pkg::OUT_W] !== want.row)
                    report_mismatch($sformatf("row got %0d expected %0d",
                                              $signed(m_tdata[2*p2hc_pkg::OUT_W-1:p2hc_pkg::OUT_W]),
                                              $signed(want.row)));
            end
            cells_seen++;
        end
    end

    task automatic write_reg(p2hc_pkg::reg_idx_t idx, logic [p2hc_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            p2hc_pkg::REG_COLUMN_SPACING: col_spacing = value;
            p2hc_pkg::REG_ROW_SPACING:    row_spacing = value;
            p2hc_pkg::REG_SLOPE_RUN:      edge_run = value;
            p2hc_pkg::REG_SLOPE_RISE:     edge_rise = value;
            default: ;
        endcase
    endtask

    task automatic program_grid(int cs, int rs, int run, int rise);
        write_reg(p2hc_pkg::REG_COLUMN_SPACING, p2hc_pkg::CFG_W'(cs));
        write_reg(p2hc_pkg::REG_ROW_SPACING, p2hc_pkg::CFG_W'(rs));
        write_reg(p2hc_pkg::REG_SLOPE_RUN, p2hc_pkg::CFG_W'(run));
        write_reg(p2hc_pkg::REG_SLOPE_RISE, p2hc_pkg::CFG_W'(rise));
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(int x, int y);
        logic [p2hc_pkg::COORD_BITS-1:0] px, py;
        px = p2hc_pkg::COORD_BITS'(x);
        py = p2hc_pkg::COORD_BITS'(y);
        pixel_words.insert(pixel_words.size(), {py, px});
    endtask

    task automatic queue_random(int count);
        int x, y, xs, ys;
        xs = (col_spacing == 0) ? 1 : int'(col_spacing);
        ys = (row_spacing == 0) ? 1 : int'(row_spacing);
        repeat (count)
        begin
            if ($urandom_range(9) < 7)
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end
            else
            begin
                // stay near the origin, where column and row -1 show up
                x = $urandom_range(2 * xs + int'(edge_run));
                y = $urandom_range(2 * ys + int'(edge_rise));
                if (x > 4095)
                    x = 4095;
                if (y > 4095)
                    y = 4095;
            end
            queue_pixel(x, y);
        end
    endtask

    task automatic drain;
        while (pixel_words.size() != 0 || s_tvalid || cells_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset grid: 48, 64, 16, 32
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(2730, 1365);
        queue_pixel(1365, 2730);
        queue_pixel(96, 0);
        queue_pixel(96, 40);
        queue_pixel(106, 32);
        queue_pixel(126, 70);
        queue_pixel(149, 0);
        queue_pixel(149, 40);
        queue_pixel(149, 63);
        queue_pixel(166, 10);
        queue_pixel(166, 100);
        queue_pixel(70, 31);
        queue_pixel(70, 32);
        queue_pixel(15, 63);
        queue_pixel(16, 63);
        queue_pixel(47, 5);
        queue_pixel(63, 63);
        queue_pixel(64, 33);
        queue_pixel(95, 0);
        queue_random(120);
        drain();

        program_grid(1, 1, 0, 0);
        queue_random(140);
        drain();

        program_grid(1023, 1023, 1023, 1023);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(2046, 0);
        queue_pixel(1500, 10);
        queue_random(140);
        drain();

        steady = 1'b1;
        program_grid(0, 0, 1023, 0);
        queue_random(150);
        drain();
        steady = 1'b0;

        program_grid(5, 7, 12, 3);
        queue_random(150);
        drain();

        program_grid(1023, 1, 1, 1023);
        queue_pixel(1100, 0);
        queue_pixel(4095, 0);
        queue_random(140);
        drain();

        program_grid($urandom_range(1, 1023), $urandom_range(1, 1023),
                     $urandom_range(1023), $urandom_range(1023));
        queue_random(140);
        drain();

        program_grid($urandom_range(1, 64), $urandom_range(1, 64),
                     $urandom_range(64), $urandom_range(64));
        queue_random(140);
        drain();

        program_grid(2, 1023, 1, 1023);
        queue_random(100);
        drain();

        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("pixel_to_hex_cell_top: match");
        else
            $display("pixel_to_hex_cell_top: mismatch");
        $finish;
    end

endmodule

// ===== pixel_to_hex_cell_top.f =====
+incdir+rtl
rtl/p2hc_pkg.sv
rtl/p2hc_cfg.sv
rtl/p2hc_div.sv
rtl/p2hc_sel.sv
rtl/pixel_to_hex_cell_top.sv
rtl/p2hc_check.sv
tb/pixel_to_hex_cell_top_test.sv
